FILE: sv/clatp_pkg.sv
// Shared types, constants and character decoding for the command-line token parser.
package clatp_pkg;

  localparam int NUMBER_BITS = 32;
  localparam int VALUE_W     = 48;
  localparam int CNT_W       = 5;
  localparam int GRP_W       = 17;
  localparam int WIDE_W      = 21;
  localparam int GCNT_W      = 3;

  localparam logic [CNT_W-1:0] CNT_MAX       = 5'd31;
  localparam logic [CNT_W-1:0] NUM_LEN_MAX   = 5'd10;
  localparam logic [CNT_W-1:0] QUAD_LEN_MAX  = 5'd16;
  localparam logic [CNT_W-1:0] GROUPS_LEN    = 5'd14;
  localparam logic [CNT_W-1:0] IDX_PREFIX_X  = 5'd1;
  localparam logic [CNT_W-1:0] IDX_COLON_A   = 5'd4;
  localparam logic [CNT_W-1:0] IDX_COLON_B   = 5'd9;

  localparam logic [GCNT_W-1:0] QUAD_GROUPS = 3'd4;
  localparam logic [GCNT_W-1:0] HEX_GROUPS  = 3'd3;

  localparam logic [WIDE_W-1:0] OCTET_MAX = 21'd255;
  localparam logic [WIDE_W-1:0] HEXGRP_MAX = 21'h0ffff;

  // Token formats (same coding as the kind input)
  localparam logic [1:0] FMT_NUMBER = 2'd0;
  localparam logic [1:0] FMT_QUAD   = 2'd1;
  localparam logic [1:0] FMT_GROUPS = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LENGTH  = 2'd1;
  localparam logic [1:0] ST_FORMAT  = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;

  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
  } hex_dec_t;

  // Snapshot of a finished token, handed from front to back
  typedef struct packed {
    logic                   missing;
    logic [1:0]             fmt;
    logic [CNT_W-1:0]       cnt;
    logic [NUMBER_BITS-1:0] acc;
    logic [GRP_W-1:0]       grp;
    logic [GCNT_W-1:0]      gcnt;
    logic [VALUE_W-1:0]     packed_val;
    logic                   fmt_err;
    logic                   last_sep;
    logic                   colon_bad;
  } token_req_t;

  function automatic hex_dec_t hex_decode(input logic [7:0] c);
    hex_dec_t r;
    r.valid = 1'b0;
    r.digit = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r.valid = 1'b1;
      r.digit = 4'(c - CH_ZERO);
    end else if (c >= CH_UA && c <= CH_UF) begin
      r.valid = 1'b1;
      r.digit = 4'(c - CH_UA + 8'd10);
    end
    return r;
  endfunction

endpackage

FILE: sv/clatp_front.sv
// Front end: tokenises characters, accumulates the token, requests at its end or line end.
module clatp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [1:0]                kind,
  input  logic [7:0]                ch,
  input  logic                      line_end,
  output logic                      req_push,
  output clatp_pkg::token_req_t     req
);

  logic                                in_token;
  logic [1:0]                          fmt;
  logic [clatp_pkg::CNT_W-1:0]         cnt;
  logic [clatp_pkg::NUMBER_BITS-1:0]   acc;
  logic                                use_hex;
  logic [clatp_pkg::GRP_W-1:0]         grp;
  logic [clatp_pkg::GCNT_W-1:0]        gcnt;
  logic [clatp_pkg::VALUE_W-1:0]       packed_val;
  logic                                fmt_err;
  logic                                first_zero;
  logic                                last_sep;
  logic                                colon_bad;

  logic [1:0]                          fmt_next;
  logic [clatp_pkg::CNT_W-1:0]         cnt_next;
  logic [clatp_pkg::NUMBER_BITS-1:0]   acc_next;
  logic                                use_hex_next;
  logic [clatp_pkg::GRP_W-1:0]         grp_next;
  logic [clatp_pkg::GCNT_W-1:0]        gcnt_next;
  logic [clatp_pkg::VALUE_W-1:0]       packed_next;
  logic                                fmt_err_next;
  logic                                first_zero_next;
  logic                                last_sep_next;
  logic                                colon_bad_next;

  logic                                is_sep;
  logic                                is_dec;
  logic [clatp_pkg::CNT_W-1:0]         idx;
  logic [clatp_pkg::GRP_W-1:0]         b_grp;
  logic [clatp_pkg::GCNT_W-1:0]        b_gcnt;
  logic [clatp_pkg::GCNT_W-1:0]        gcnt_inc;
  logic [clatp_pkg::VALUE_W-1:0]       b_packed;
  logic                                b_fe;
  logic [clatp_pkg::NUMBER_BITS-1:0]   b_acc;
  logic                                b_hex;
  logic                                b_fz;
  logic [clatp_pkg::WIDE_W-1:0]        wide;
  clatp_pkg::hex_dec_t                 hd;

  assign is_sep = (ch == clatp_pkg::CH_SPACE) || (ch == clatp_pkg::CH_NUL);
  assign is_dec = (ch >= clatp_pkg::CH_ZERO) && (ch <= clatp_pkg::CH_NINE);
  assign hd     = clatp_pkg::hex_decode(ch);

  // Request when the line ends, or a separator closes an open token
  assign req_push = accept && (line_end || (is_sep && in_token));

  always_comb begin
    req.missing    = !in_token;
    req.fmt        = in_token ? fmt : kind;
    req.cnt        = cnt;
    req.acc        = acc;
    req.grp        = grp;
    req.gcnt       = gcnt;
    req.packed_val = packed_val;
    req.fmt_err    = fmt_err;
    req.last_sep   = last_sep;
    req.colon_bad  = colon_bad;
  end

  always_comb begin
    // Start from a cleared token when this character opens one
    fmt_next   = in_token ? fmt : kind;
    idx        = in_token ? cnt : '0;
    b_acc      = in_token ? acc : '0;
    b_hex      = in_token ? use_hex : 1'b0;
    b_grp      = in_token ? grp : '0;
    b_gcnt     = in_token ? gcnt : '0;
    b_packed   = in_token ? packed_val : '0;
    b_fe       = in_token ? fmt_err : 1'b0;
    b_fz       = in_token ? first_zero : 1'b0;

    cnt_next        = (idx != clatp_pkg::CNT_MAX) ? idx + 1'b1 : idx;
    acc_next        = b_acc;
    use_hex_next    = b_hex;
    grp_next        = b_grp;
    gcnt_next       = b_gcnt;
    packed_next     = b_packed;
    fmt_err_next    = b_fe;
    first_zero_next = b_fz;
    last_sep_next   = in_token ? last_sep : 1'b0;
    colon_bad_next  = in_token ? colon_bad : 1'b0;
    gcnt_inc        = b_gcnt + 1'b1;
    wide            = '0;

    case (fmt_next)
      clatp_pkg::FMT_NUMBER: begin
        if (idx == '0) begin
          first_zero_next = (ch == clatp_pkg::CH_ZERO);
        end
        if (idx == clatp_pkg::IDX_PREFIX_X && b_fz && ch == clatp_pkg::CH_UX) begin
          use_hex_next = 1'b1;
        end else if (hd.valid) begin
          if (b_hex) begin
            acc_next = (b_acc << 4) + clatp_pkg::NUMBER_BITS'(hd.digit);
          end else begin
            acc_next = (b_acc << 3) + (b_acc << 1) + clatp_pkg::NUMBER_BITS'(hd.digit);
          end
        end
      end
      clatp_pkg::FMT_QUAD: begin
        last_sep_next = 1'b0;
        if (is_dec) begin
          if (!b_fe) begin
            wide = (clatp_pkg::WIDE_W'(b_grp) << 3) + (clatp_pkg::WIDE_W'(b_grp) << 1)
                 + clatp_pkg::WIDE_W'(hd.digit);
            grp_next = wide[clatp_pkg::GRP_W-1:0];
            if (wide > clatp_pkg::OCTET_MAX) fmt_err_next = 1'b1;
          end
        end else if (ch == clatp_pkg::CH_DOT) begin
          last_sep_next = 1'b1;
          if (!b_fe) begin
            packed_next = (b_packed << 8) | clatp_pkg::VALUE_W'(b_grp);
            grp_next    = '0;
            gcnt_next   = gcnt_inc;
            if (gcnt_inc > clatp_pkg::QUAD_GROUPS) fmt_err_next = 1'b1;
          end
        end else begin
          fmt_err_next = 1'b1;
        end
      end
      clatp_pkg::FMT_GROUPS: begin
        last_sep_next = 1'b0;
        if ((idx == clatp_pkg::IDX_COLON_A || idx == clatp_pkg::IDX_COLON_B)
            && ch != clatp_pkg::CH_COLON) begin
          colon_bad_next = 1'b1;
        end
        if (hd.valid) begin
          if (!b_fe) begin
            wide = (clatp_pkg::WIDE_W'(b_grp) << 4) + clatp_pkg::WIDE_W'(hd.digit);
            grp_next = wide[clatp_pkg::GRP_W-1:0];
            if (wide > clatp_pkg::HEXGRP_MAX) fmt_err_next = 1'b1;
          end
        end else if (ch == clatp_pkg::CH_COLON) begin
          last_sep_next = 1'b1;
          if (!b_fe) begin
            packed_next = (b_packed << 16) | clatp_pkg::VALUE_W'(b_grp);
            grp_next    = '0;
            gcnt_next   = gcnt_inc;
            if (gcnt_inc > clatp_pkg::HEX_GROUPS) fmt_err_next = 1'b1;
          end
        end else begin
          fmt_err_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token <= 1'b0;
    end else if (accept) begin
      if (line_end || is_sep) begin
        in_token <= 1'b0;
      end else begin
        in_token <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !line_end && !is_sep) begin
      fmt        <= fmt_next;
      cnt        <= cnt_next;
      acc        <= acc_next;
      use_hex    <= use_hex_next;
      grp        <= grp_next;
      gcnt       <= gcnt_next;
      packed_val <= packed_next;
      fmt_err    <= fmt_err_next;
      first_zero <= first_zero_next;
      last_sep   <= last_sep_next;
      colon_bad  <= colon_bad_next;
    end
  end

endmodule

FILE: sv/clatp_queue.sv
// Two-entry queue of finished-token requests between front and back.
module clatp_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  clatp_pkg::token_req_t     push_req,
  input  logic                      pop,
  output logic                      full,
  output logic                      valid,
  output clatp_pkg::token_req_t     head
);

  clatp_pkg::token_req_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_req;
  end

endmodule

FILE: sv/clatp_back.sv
// Back end: closes the last group, checks length and format, and holds the result.
module clatp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  clatp_pkg::token_req_t             req,
  output logic                              req_pop,
  input  logic                              pop,
  output logic                              empty,
  output logic [clatp_pkg::VALUE_W-1:0]     value,
  output logic [1:0]                        status,
  output logic [1:0]                        format_out
);

  logic                               out_valid;
  logic                               load;
  logic                               do_close;
  logic [clatp_pkg::GCNT_W-1:0]       gcnt_f;
  logic                               fe_f;
  logic [clatp_pkg::VALUE_W-1:0]      packed_f;
  logic [clatp_pkg::VALUE_W-1:0]      value_next;
  logic [1:0]                         status_next;

  assign empty   = !out_valid;
  assign load    = req_valid && (!out_valid || pop);
  assign req_pop = load;

  always_comb begin
    do_close    = !req.fmt_err && !req.last_sep;
    gcnt_f      = do_close ? req.gcnt + 1'b1 : req.gcnt;
    fe_f        = req.fmt_err;
    packed_f    = req.packed_val;
    value_next  = '0;
    status_next = clatp_pkg::ST_OK;

    if (req.fmt == clatp_pkg::FMT_QUAD) begin
      if (do_close) packed_f = (req.packed_val << 8) | clatp_pkg::VALUE_W'(req.grp);
      if (do_close && gcnt_f > clatp_pkg::QUAD_GROUPS) fe_f = 1'b1;
    end else begin
      if (do_close) packed_f = (req.packed_val << 16) | clatp_pkg::VALUE_W'(req.grp);
      if (do_close && gcnt_f > clatp_pkg::HEX_GROUPS) fe_f = 1'b1;
    end

    if (req.missing) begin
      status_next = clatp_pkg::ST_MISSING;
    end else begin
      case (req.fmt)
        clatp_pkg::FMT_NUMBER: begin
          if (req.cnt == '0 || req.cnt > clatp_pkg::NUM_LEN_MAX) begin
            status_next = clatp_pkg::ST_LENGTH;
          end else begin
            value_next = clatp_pkg::VALUE_W'(req.acc);
          end
        end
        clatp_pkg::FMT_QUAD: begin
          if (req.cnt == '0 || req.cnt > clatp_pkg::QUAD_LEN_MAX) begin
            status_next = clatp_pkg::ST_LENGTH;
          end else if (fe_f || gcnt_f != clatp_pkg::QUAD_GROUPS) begin
            status_next = clatp_pkg::ST_FORMAT;
          end else begin
            value_next = packed_f;
          end
        end
        clatp_pkg::FMT_GROUPS: begin
          if (req.cnt != clatp_pkg::GROUPS_LEN || req.colon_bad) begin
            status_next = clatp_pkg::ST_LENGTH;
          end else if (fe_f || gcnt_f != clatp_pkg::HEX_GROUPS) begin
            status_next = clatp_pkg::ST_FORMAT;
          end else begin
            value_next = packed_f;
          end
        end
        default: begin
          status_next = clatp_pkg::ST_FORMAT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value      <= value_next;
      status     <= status_next;
      format_out <= req.fmt;
    end
  end

endmodule

FILE: sv/cli_argument_token_parser.sv
// Top level of the command-line token parser: front end, request queue and back end.
// Takes one character per cycle; the request for a token that a character ends passes
// through the queue stage, then the result register. The front end stalls only while
// the two-entry request queue is full, which happens when results are not being popped.
module cli_argument_token_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      kind,
  input  logic [7:0]                      ch,
  input  logic                            line_end,
  output logic                            empty,
  input  logic                            pop,
  output logic [clatp_pkg::VALUE_W-1:0]   value,
  output logic [1:0]                      status,
  output logic [1:0]                      format_out
);

  logic                  accept;
  logic                  req_push;
  logic                  q_valid;
  logic                  q_pop;
  clatp_pkg::token_req_t req_in;
  clatp_pkg::token_req_t req_head;

  assign accept = push && !full;

  clatp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .kind     (kind),
    .ch       (ch),
    .line_end (line_end),
    .req_push (req_push),
    .req      (req_in)
  );

  clatp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (req_push),
    .push_req (req_in),
    .pop      (q_pop),
    .full     (full),
    .valid    (q_valid),
    .head     (req_head)
  );

  clatp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (q_valid),
    .req        (req_head),
    .req_pop    (q_pop),
    .pop        (pop),
    .empty      (empty),
    .value      (value),
    .status     (status),
    .format_out (format_out)
  );

endmodule
